### design/segmented_semiglobal_alignment_top_macros.svh
// Assertion macros shared by the alignment block.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SEGMENTED_SEMIGLOBAL_ALIGNMENT_TOP_MACROS_SVH
`define SEGMENTED_SEMIGLOBAL_ALIGNMENT_TOP_MACROS_SVH

// Same-cycle implication.
`define SGA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SGA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/sga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sga_pkg
// Types, codes and cost helpers of the segmented semi-global aligner.
// ----------------------------------------------------------------------------
package sga_pkg;

  localparam int MAX_LEN = 128;
  localparam int IDX_W   = 7;
  localparam int CNT_W   = 8;
  localparam int PC_W    = 9;
  localparam int COST_W  = 10;
  localparam int MC_W    = 4;

  localparam logic [7:0] GAP_CH = 8'h2D;
  localparam logic [COST_W-1:0] COST_MAX = 10'd1023;

  // Input function codes.
  localparam logic [2:0] FN_LOAD_READ = 3'd0;
  localparam logic [2:0] FN_LOAD_REF  = 3'd1;
  localparam logic [2:0] FN_CLEAR     = 3'd2;
  localparam logic [2:0] FN_ALIGN     = 3'd3;
  localparam logic [2:0] FN_READ_COL  = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_COLUMN  = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  // Path step codes.
  localparam logic [1:0] OP_DEL = 2'd0;
  localparam logic [1:0] OP_INS = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FROW, ST_FUP, ST_FDG, ST_FWR, ST_FDONE,
    ST_TSTEP, ST_TR1, ST_TR2, ST_TR3, ST_TDEC, ST_SUM,
    ST_RISS, ST_REMIT, ST_NONE
  } state_t;

  typedef struct packed {
    logic       we;
    logic [6:0] wa;
    logic [8:0] wd;
    logic       re;
    logic [6:0] ra;
  } rd_req_t;

  typedef struct packed {
    logic        we;
    logic [6:0]  wa;
    logic [15:0] wd;
    logic        re;
    logic [6:0]  ra;
  } rf_req_t;

  typedef struct packed {
    logic        we;
    logic [13:0] wa;
    logic [9:0]  wd;
    logic        re;
    logic [13:0] ra;
  } cm_req_t;

  typedef struct packed {
    logic       we;
    logic [7:0] wa;
    logic [1:0] wd;
    logic       re;
    logic [7:0] ra;
  } pa_req_t;

  function automatic logic is_lower(input logic [7:0] ch);
    return (ch >= 8'h61) && (ch <= 8'h7A);
  endfunction

  function automatic logic [7:0] upper_of(input logic [7:0] ch);
    return is_lower(ch) ? ch - 8'h20 : ch;
  endfunction

  // Cost of reference byte against read byte.
  function automatic logic [MC_W-1:0] pair_cost(input logic [7:0] refc,
                                                input logic [7:0] rdc,
                                                input logic [MC_W-1:0] mc);
    logic [MC_W-1:0] res;
    if (is_lower(rdc)) res = '0;
    else if (upper_of(refc) == rdc) res = '0;
    else res = mc;
    return res;
  endfunction

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [MC_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {{(COST_W-MC_W+1){1'b0}}, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  // Matrix cell value: row zero and column zero are implicit.
  function automatic logic [COST_W-1:0] cell_val(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c,
                                                 input logic [COST_W-1:0] q);
    logic [COST_W-1:0] res;
    if (r == '0) res = '0;
    else if (c == '0) res = {{(COST_W-CNT_W){1'b0}}, r};
    else res = q;
    return res;
  endfunction

  // Address of cell (r, c) with r and c both at least one.
  function automatic logic [13:0] cell_addr(input logic [CNT_W-1:0] r,
                                            input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] rm;
    logic [CNT_W-1:0] cm;
    rm = r - 8'd1;
    cm = c - 8'd1;
    return {rm[IDX_W-1:0], cm[IDX_W-1:0]};
  endfunction

endpackage

### design/sga_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sga_in_if
// Input channel: one command item per transfer.
// ----------------------------------------------------------------------------
interface sga_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] read_base;
  logic       segment_end;
  logic [7:0] ref_base;
  logic [7:0] raw_base;

  modport source (output valid, func, read_base, segment_end, ref_base, raw_base,
                  input ready);
  modport sink (input valid, func, read_base, segment_end, ref_base, raw_base,
                output ready);
endinterface

### design/sga_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sga_out_if
// Result channel: one summary or alignment column per transfer.
// ----------------------------------------------------------------------------
interface sga_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] read_out;
  logic [7:0] raw_out;
  logic [7:0] ref_out;
  logic [1:0] step_kind;
  logic [9:0] total_cost;
  logic [8:0] path_length;
  logic       no_path;
  logic       last_column;

  modport source (output valid, kind, read_out, raw_out, ref_out, step_kind,
                  total_cost, path_length, no_path, last_column, input ready);
  modport sink (input valid, kind, read_out, raw_out, ref_out, step_kind,
                total_cost, path_length, no_path, last_column, output ready);
endinterface

### design/sga_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sga_ram
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sga_ram #(
  parameter int W = 8,
  parameter int D = 128
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] wa,
  input  logic [W-1:0]         wd,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] ra,
  output logic [W-1:0]         q
);
  logic [W-1:0] mem [D];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read port, data held until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      q <= mem[ra];
    end
  end
endmodule

### design/sga_ctrl.sv
`timescale 1ns / 1ps
`include "segmented_semiglobal_alignment_top_macros.svh"
// ----------------------------------------------------------------------------
// sga_ctrl
// Sequencer for loads, matrix fill, traceback and column readout.
// ----------------------------------------------------------------------------
module sga_ctrl
  import sga_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sga_in_if.sink            in_ch,
  sga_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [MC_W-1:0]   cfg_data,
  output rd_req_t           rd_req,
  input  logic [8:0]        rd_q,
  output rf_req_t           rf_req,
  input  logic [15:0]       rf_q,
  output cm_req_t           cm_req,
  input  logic [COST_W-1:0] cm_q,
  output pa_req_t           pa_req,
  input  logic [1:0]        pa_q
);
  state_t state_r, state_nxt;
  logic [MC_W-1:0]   mc_r, mc_nxt;
  logic [CNT_W-1:0]  rcnt_r, rcnt_nxt, fcnt_r, fcnt_nxt;
  logic [CNT_W-1:0]  r_r, r_nxt, c_r, c_nxt;
  logic [CNT_W-1:0]  rq_r, rq_nxt, rqc_r, rqc_nxt;
  logic [COST_W-1:0] left_r, left_nxt, up_r, up_nxt, cur_r, cur_nxt;
  logic [COST_W-1:0] total_r, total_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt, ep_r, ep_nxt;
  logic [CNT_W-1:0]  wrow_r, wrow_nxt, wcol_r, wcol_nxt;
  logic              stuck_r, stuck_nxt;

  logic              ov_r, ov_nxt;
  logic [1:0]        kind_r, kind_nxt, sk_r, sk_nxt;
  logic [7:0]        rdo_r, rdo_nxt, rwo_r, rwo_nxt, rfo_r, rfo_nxt;
  logic [COST_W-1:0] tc_r, tc_nxt;
  logic [PC_W-1:0]   pl_r, pl_nxt;
  logic              np_r, np_nxt, lc_r, lc_nxt;

  logic              in_fire, out_free;
  logic [COST_W-1:0] cval, delv, insv, subv, minv;
  logic [7:0]        rd_b, rf_b, rw_b;
  logic              seg;
  logic [PC_W-1:0]   pidx;
  logic              cell_wr_ok;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;

  // Cost terms shared by the fill and the traceback.
  assign rd_b = rd_q[7:0];
  assign seg  = rd_q[8];
  assign rf_b = rf_q[7:0];
  assign rw_b = rf_q[15:8];
  assign cval = cell_val(rq_r, rqc_r, cm_q);
  assign delv = seg ? left_r : sat_add(left_r, pair_cost(rf_b, GAP_CH, mc_r));
  assign insv = sat_add(up_r, pair_cost(GAP_CH, rd_b, mc_r));
  assign subv = sat_add(cval, pair_cost(rf_b, rd_b, mc_r));
  always_comb begin
    minv = (delv < insv) ? delv : insv;
    if (subv < minv) minv = subv;
  end
  assign pidx = pc_r - ep_r - 9'd1;

  // Register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mc_r    <= 4'd2;
      rcnt_r  <= '0;
      fcnt_r  <= '0;
      pc_r    <= '0;
      ep_r    <= '0;
      wrow_r  <= '0;
      wcol_r  <= '0;
      stuck_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mc_r    <= mc_nxt;
      rcnt_r  <= rcnt_nxt;
      fcnt_r  <= fcnt_nxt;
      pc_r    <= pc_nxt;
      ep_r    <= ep_nxt;
      wrow_r  <= wrow_nxt;
      wcol_r  <= wcol_nxt;
      stuck_r <= stuck_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r     <= r_nxt;
    c_r     <= c_nxt;
    rq_r    <= rq_nxt;
    rqc_r   <= rqc_nxt;
    left_r  <= left_nxt;
    up_r    <= up_nxt;
    cur_r   <= cur_nxt;
    total_r <= total_nxt;
    kind_r  <= kind_nxt;
    sk_r    <= sk_nxt;
    rdo_r   <= rdo_nxt;
    rwo_r   <= rwo_nxt;
    rfo_r   <= rfo_nxt;
    tc_r    <= tc_nxt;
    pl_r    <= pl_nxt;
    np_r    <= np_nxt;
    lc_r    <= lc_nxt;
  end

  // Next state and memory requests.
  always_comb begin
    state_nxt = state_r;
    mc_nxt    = cfg_we ? cfg_data : mc_r;
    rcnt_nxt  = rcnt_r;
    fcnt_nxt  = fcnt_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    rq_nxt    = rq_r;
    rqc_nxt   = rqc_r;
    left_nxt  = left_r;
    up_nxt    = up_r;
    cur_nxt   = cur_r;
    total_nxt = total_r;
    pc_nxt    = pc_r;
    ep_nxt    = ep_r;
    wrow_nxt  = wrow_r;
    wcol_nxt  = wcol_r;
    stuck_nxt = stuck_r;
    ov_nxt    = ov_r && !out_ch.ready;
    kind_nxt  = kind_r;
    sk_nxt    = sk_r;
    rdo_nxt   = rdo_r;
    rwo_nxt   = rwo_r;
    rfo_nxt   = rfo_r;
    tc_nxt    = tc_r;
    pl_nxt    = pl_r;
    np_nxt    = np_r;
    lc_nxt    = lc_r;
    rd_req    = '0;
    rf_req    = '0;
    cm_req    = '0;
    pa_req    = '0;
    in_ch.ready = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // Ready is high throughout this state, so valid marks a transfer.
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          case (in_ch.func)
            FN_LOAD_READ: begin
              if (rcnt_r < CNT_W'(MAX_LEN)) begin
                rd_req.we = 1'b1;
                rd_req.wa = rcnt_r[IDX_W-1:0];
                rd_req.wd = {in_ch.segment_end, in_ch.read_base};
                rcnt_nxt  = rcnt_r + 8'd1;
              end
            end
            FN_LOAD_REF: begin
              if (fcnt_r < CNT_W'(MAX_LEN)) begin
                rf_req.we = 1'b1;
                rf_req.wa = fcnt_r[IDX_W-1:0];
                rf_req.wd = {in_ch.raw_base, in_ch.ref_base};
                fcnt_nxt  = fcnt_r + 8'd1;
              end
            end
            FN_CLEAR: begin
              rcnt_nxt  = '0;
              fcnt_nxt  = '0;
              pc_nxt    = '0;
              ep_nxt    = '0;
              wrow_nxt  = '0;
              wcol_nxt  = '0;
              stuck_nxt = 1'b0;
            end
            FN_ALIGN: begin
              r_nxt = 8'd1;
              if (rcnt_r == '0 || fcnt_r == '0) state_nxt = ST_FDONE;
              else state_nxt = ST_FROW;
            end
            FN_READ_COL: begin
              if (ep_r >= pc_r) state_nxt = ST_NONE;
              else state_nxt = ST_RISS;
            end
            default: ;
          endcase
        end
      end

      // Matrix fill, one cell at a time: up read, diagonal read, then write.
      ST_FROW: begin
        rd_req.re = 1'b1;
        rd_req.ra = 7'(r_r - 8'd1);
        c_nxt     = 8'd1;
        left_nxt  = {{(COST_W-CNT_W){1'b0}}, r_r};
        state_nxt = ST_FUP;
      end
      ST_FUP: begin
        cm_req.re = 1'b1;
        cm_req.ra = cell_addr(r_r - 8'd1, c_r);
        rq_nxt    = r_r - 8'd1;
        rqc_nxt   = c_r;
        rf_req.re = 1'b1;
        rf_req.ra = 7'(c_r - 8'd1);
        state_nxt = ST_FDG;
      end
      ST_FDG: begin
        up_nxt    = cval;
        cm_req.re = 1'b1;
        cm_req.ra = cell_addr(r_r - 8'd1, c_r - 8'd1);
        rq_nxt    = r_r - 8'd1;
        rqc_nxt   = c_r - 8'd1;
        state_nxt = ST_FWR;
      end
      ST_FWR: begin
        cm_req.we = 1'b1;
        cm_req.wa = cell_addr(r_r, c_r);
        cm_req.wd = minv;
        left_nxt  = minv;
        if (c_r == fcnt_r) begin
          if (r_r == rcnt_r) state_nxt = ST_FDONE;
          else begin
            r_nxt     = r_r + 8'd1;
            state_nxt = ST_FROW;
          end
        end else begin
          c_nxt     = c_r + 8'd1;
          state_nxt = ST_FUP;
        end
      end
      ST_FDONE: begin
        if (rcnt_r == '0) total_nxt = '0;
        else if (fcnt_r == '0) total_nxt = {{(COST_W-CNT_W){1'b0}}, rcnt_r};
        else total_nxt = left_r;
        r_nxt     = rcnt_r;
        c_nxt     = fcnt_r;
        pc_nxt    = '0;
        stuck_nxt = 1'b0;
        state_nxt = ST_TSTEP;
      end

      // Traceback: edges need no matrix read, inner cells read four cells.
      ST_TSTEP: begin
        if ((r_r == '0 && c_r == '0) || pc_r[PC_W-1]) begin
          wrow_nxt  = r_r;
          wcol_nxt  = c_r;
          ep_nxt    = '0;
          state_nxt = ST_SUM;
        end else if (r_r == '0) begin
          pa_req.we = 1'b1;
          pa_req.wa = pc_r[PC_W-2:0];
          pa_req.wd = OP_DEL;
          c_nxt     = c_r - 8'd1;
          pc_nxt    = pc_r + 9'd1;
        end else if (c_r == '0) begin
          pa_req.we = 1'b1;
          pa_req.wa = pc_r[PC_W-2:0];
          pa_req.wd = OP_INS;
          r_nxt     = r_r - 8'd1;
          pc_nxt    = pc_r + 9'd1;
        end else begin
          cm_req.re = 1'b1;
          cm_req.ra = cell_addr(r_r, c_r);
          rq_nxt    = r_r;
          rqc_nxt   = c_r;
          rd_req.re = 1'b1;
          rd_req.ra = 7'(r_r - 8'd1);
          rf_req.re = 1'b1;
          rf_req.ra = 7'(c_r - 8'd1);
          state_nxt = ST_TR1;
        end
      end
      ST_TR1: begin
        cur_nxt   = cval;
        cm_req.re = 1'b1;
        cm_req.ra = cell_addr(r_r, c_r - 8'd1);
        rq_nxt    = r_r;
        rqc_nxt   = c_r - 8'd1;
        state_nxt = ST_TR2;
      end
      ST_TR2: begin
        left_nxt  = cval;
        cm_req.re = 1'b1;
        cm_req.ra = cell_addr(r_r - 8'd1, c_r);
        rq_nxt    = r_r - 8'd1;
        rqc_nxt   = c_r;
        state_nxt = ST_TR3;
      end
      ST_TR3: begin
        up_nxt    = cval;
        cm_req.re = 1'b1;
        cm_req.ra = cell_addr(r_r - 8'd1, c_r - 8'd1);
        rq_nxt    = r_r - 8'd1;
        rqc_nxt   = c_r - 8'd1;
        state_nxt = ST_TDEC;
      end
      ST_TDEC: begin
        pa_req.wa = pc_r[PC_W-2:0];
        state_nxt = ST_TSTEP;
        if (delv == cur_r) begin
          pa_req.we = 1'b1;
          pa_req.wd = OP_DEL;
          c_nxt     = c_r - 8'd1;
          pc_nxt    = pc_r + 9'd1;
        end else if (insv == cur_r) begin
          pa_req.we = 1'b1;
          pa_req.wd = OP_INS;
          r_nxt     = r_r - 8'd1;
          pc_nxt    = pc_r + 9'd1;
        end else if (subv == cur_r) begin
          pa_req.we = 1'b1;
          pa_req.wd = OP_SUB;
          r_nxt     = r_r - 8'd1;
          c_nxt     = c_r - 8'd1;
          pc_nxt    = pc_r + 9'd1;
        end else begin
          // Dead end: stop and keep the part already traced.
          stuck_nxt = 1'b1;
          wrow_nxt  = r_r;
          wcol_nxt  = c_r;
          ep_nxt    = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          kind_nxt  = KIND_SUMMARY;
          rdo_nxt   = '0;
          rwo_nxt   = '0;
          rfo_nxt   = '0;
          sk_nxt    = OP_DEL;
          tc_nxt    = total_r;
          pl_nxt    = pc_r;
          np_nxt    = stuck_r;
          lc_nxt    = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      // Column readout walks the path from its far end.
      ST_RISS: begin
        pa_req.re = 1'b1;
        pa_req.ra = pidx[PC_W-2:0];
        rd_req.re = 1'b1;
        rd_req.ra = wrow_r[IDX_W-1:0];
        rf_req.re = 1'b1;
        rf_req.ra = wcol_r[IDX_W-1:0];
        state_nxt = ST_REMIT;
      end
      ST_REMIT: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          kind_nxt = KIND_COLUMN;
          sk_nxt   = pa_q;
          rdo_nxt  = (pa_q != OP_DEL && !wrow_r[CNT_W-1]) ? rd_b : GAP_CH;
          rwo_nxt  = (pa_q != OP_INS && !wcol_r[CNT_W-1]) ? rw_b : GAP_CH;
          rfo_nxt  = (pa_q != OP_INS && !wcol_r[CNT_W-1]) ? rf_b : GAP_CH;
          tc_nxt   = '0;
          pl_nxt   = '0;
          np_nxt   = stuck_r;
          lc_nxt   = (ep_r + 9'd1) == pc_r;
          if (pa_q != OP_DEL) wrow_nxt = wrow_r + 8'd1;
          if (pa_q != OP_INS) wcol_nxt = wcol_r + 8'd1;
          ep_nxt    = ep_r + 9'd1;
          state_nxt = ST_IDLE;
        end
      end
      ST_NONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          kind_nxt  = KIND_NONE;
          rdo_nxt   = '0;
          rwo_nxt   = '0;
          rfo_nxt   = '0;
          sk_nxt    = OP_DEL;
          tc_nxt    = '0;
          pl_nxt    = '0;
          np_nxt    = 1'b0;
          lc_nxt    = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register outputs.
  assign out_ch.valid       = ov_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.read_out    = rdo_r;
  assign out_ch.raw_out     = rwo_r;
  assign out_ch.ref_out     = rfo_r;
  assign out_ch.step_kind   = sk_r;
  assign out_ch.total_cost  = tc_r;
  assign out_ch.path_length = pl_r;
  assign out_ch.no_path     = np_r;
  assign out_ch.last_column = lc_r;

  // A cost write belongs to the fill and lies inside the loaded area.
  assign cell_wr_ok = state_r == ST_FWR && r_r != '0 && c_r != '0 &&
                      r_r <= rcnt_r && c_r <= fcnt_r;

  // Checks on the sequencer.
  `SGA_ASSERT_IMPL(a_cell_write, cm_req.we, cell_wr_ok, "cost write outside the filled area")
  `SGA_ASSERT_IMPL(a_path_write, pa_req.we, !pc_r[PC_W-1], "path write beyond the path store")
  `SGA_ASSERT_NEXT(a_align_busy, in_fire && in_ch.func == FN_ALIGN, state_r != ST_IDLE, "align did not start")
endmodule

### design/segmented_semiglobal_alignment_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_semiglobal_alignment_top
// Segmented semi-global aligner with traceback and column readout.
// ----------------------------------------------------------------------------
// Channel  Direction  Carries
// in_ch    in         func, read_base, segment_end, ref_base, raw_base
// out_ch   out        kind, aligned bytes, step_kind, cost, length, flags
// cfg_*    in         mismatch_cost, written whenever cfg_we is high
//
// Loads, clear and unused codes are taken in the idle state; a column read
// goes through the path and base store reads, then the column emit state.
// Align fills the matrix with two cost reads and a write per cell (one cost
// RAM read port), then traces back with four cost reads per inner step.
// Reset is synchronous; no clearing pass is needed after it.
// A stalled result holds the sequencer in its emit state; loads are taken
// meanwhile once it is idle.
module segmented_semiglobal_alignment_top
  import sga_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  sga_in_if.sink          in_ch,
  sga_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [MC_W-1:0] cfg_data
);
  rd_req_t           rd_req;
  rf_req_t           rf_req;
  cm_req_t           cm_req;
  pa_req_t           pa_req;
  logic [8:0]        rd_q;
  logic [15:0]       rf_q;
  logic [COST_W-1:0] cm_q;
  logic [1:0]        pa_q;

  sga_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .cfg_we, .cfg_data,
    .rd_req, .rd_q, .rf_req, .rf_q, .cm_req, .cm_q, .pa_req, .pa_q
  );

  // Read bases with segment-end flags.
  sga_ram #(.W(9), .D(MAX_LEN)) u_read_ram (
    .clk, .we(rd_req.we), .wa(rd_req.wa), .wd(rd_req.wd),
    .re(rd_req.re), .ra(rd_req.ra), .q(rd_q)
  );

  // Reference columns with their uncorrected bases.
  sga_ram #(.W(16), .D(MAX_LEN)) u_ref_ram (
    .clk, .we(rf_req.we), .wa(rf_req.wa), .wd(rf_req.wd),
    .re(rf_req.re), .ra(rf_req.ra), .q(rf_q)
  );

  // Cost matrix, inner cells only.
  sga_ram #(.W(COST_W), .D(MAX_LEN * MAX_LEN)) u_cost_ram (
    .clk, .we(cm_req.we), .wa(cm_req.wa), .wd(cm_req.wd),
    .re(cm_req.re), .ra(cm_req.ra), .q(cm_q)
  );

  // Traced path steps.
  sga_ram #(.W(2), .D(2 * MAX_LEN)) u_path_ram (
    .clk, .we(pa_req.we), .wa(pa_req.wa), .wd(pa_req.wd),
    .re(pa_req.re), .ra(pa_req.ra), .q(pa_q)
  );
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segmented semi-global aligner. A directed table
// covers the corner cases, then random load/align/readout sequences follow,
// all checked field by field against a behavioural predictor or fixed table values.
// ----------------------------------------------------------------------------
module tb_top;
  import sga_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rd;
    logic [7:0] rw;
    logic [7:0] rf;
    logic [1:0] step;
    logic [9:0] cost;
    logic [8:0] plen;
    logic       stuck;
    logic       last;
  } align_res_t;

  typedef struct {
    logic [2:0] func;
    logic [7:0] rb;
    logic       seg;
    logic [7:0] rf;
    logic [7:0] rw;
    bit         fixed;
    align_res_t res;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [MC_W-1:0] cfg_data = '0;

  sga_in_if  in_ch ();
  sga_out_if out_ch ();

  segmented_semiglobal_alignment_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state, mirroring the block's stores and walk cursors.
  logic [7:0] m_read[MAX_LEN];
  logic       m_seg[MAX_LEN];
  logic [7:0] m_ref[MAX_LEN];
  logic [7:0] m_raw[MAX_LEN];
  int         n_read, n_ref;
  int         cm[MAX_LEN+1][MAX_LEN+1];
  logic [1:0] path[2*MAX_LEN];
  int         n_path, emit_idx, w_row, w_col;
  logic       dead_end;
  int         mc_cfg;

  align_res_t expected_q[$];
  cmd_t       cmd_q[$];
  int         errors = 0;
  int         sent = 0;
  int         burst_left = 0;
  bit         hold_req = 0;

  function int base_cost(logic [7:0] r, logic [7:0] q);
    logic [7:0] ru;
    ru = (r >= 8'h61 && r <= 8'h7A) ? r - 8'h20 : r;
    if (q >= 8'h61 && q <= 8'h7A) return 0;
    if (ru == q) return 0;
    return mc_cfg;
  endfunction

  function int sat(int a, int b);
    return (a + b > 1023) ? 1023 : a + b;
  endfunction

  function int del_price(int r, int c);
    if (r > 0 && m_seg[r-1]) return cm[r][c-1];
    return sat(cm[r][c-1], base_cost(m_ref[c-1], GAP_CH));
  endfunction

  function int ins_price(int r, int c);
    return sat(cm[r-1][c], base_cost(GAP_CH, m_read[r-1]));
  endfunction

  function int sub_price(int r, int c);
    return sat(cm[r-1][c-1], base_cost(m_ref[c-1], m_read[r-1]));
  endfunction

  // Fills the cost matrix, then traces back and records the path.
  function void align_and_trace();
    int r, c, d, i, s, cur;
    logic [1:0] op;
    for (r = 0; r <= n_read; r++) cm[r][0] = r;
    for (c = 1; c <= n_ref; c++) cm[0][c] = 0;
    for (r = 1; r <= n_read; r++)
      for (c = 1; c <= n_ref; c++) begin
        d = del_price(r, c);
        i = ins_price(r, c);
        s = sub_price(r, c);
        cm[r][c] = (d < i) ? ((d < s) ? d : s) : ((i < s) ? i : s);
      end
    r = n_read;
    c = n_ref;
    n_path = 0;
    dead_end = 0;
    while ((r > 0 || c > 0) && n_path < 2 * MAX_LEN) begin
      if (r == 0) op = OP_DEL;
      else if (c == 0) op = OP_INS;
      else begin
        cur = cm[r][c];
        if (del_price(r, c) == cur) op = OP_DEL;
        else if (ins_price(r, c) == cur) op = OP_INS;
        else if (sub_price(r, c) == cur) op = OP_SUB;
        else begin
          dead_end = 1;
          break;
        end
      end
      path[n_path++] = op;
      if (op != OP_INS) c--;
      if (op != OP_DEL) r--;
    end
    w_row = r;
    w_col = c;
    emit_idx = 0;
  endfunction

  // Applies one accepted command; returns 1 when it yields a result.
  function bit predict_result(cmd_t cmd, output align_res_t res);
    logic [1:0] op;
    res = '0;
    case (cmd.func)
      FN_LOAD_READ: begin
        if (n_read < MAX_LEN) begin
          m_read[n_read] = cmd.rb;
          m_seg[n_read] = cmd.seg;
          n_read++;
        end
        return 0;
      end
      FN_LOAD_REF: begin
        if (n_ref < MAX_LEN) begin
          m_ref[n_ref] = cmd.rf;
          m_raw[n_ref] = cmd.rw;
          n_ref++;
        end
        return 0;
      end
      FN_CLEAR: begin
        n_read = 0;
        n_ref = 0;
        n_path = 0;
        emit_idx = 0;
        w_row = 0;
        w_col = 0;
        dead_end = 0;
        return 0;
      end
      FN_ALIGN: begin
        align_and_trace();
        res.kind = KIND_SUMMARY;
        res.cost = 10'(cm[n_read][n_ref]);
        res.plen = 9'(n_path);
        res.stuck = dead_end;
        return 1;
      end
      FN_READ_COL: begin
        if (emit_idx >= n_path) begin
          res.kind = KIND_NONE;
          return 1;
        end
        op = path[n_path - 1 - emit_idx];
        res.kind = KIND_COLUMN;
        res.rd = GAP_CH;
        res.rw = GAP_CH;
        res.rf = GAP_CH;
        if (op != OP_DEL && w_row < MAX_LEN) res.rd = m_read[w_row];
        if (op != OP_INS && w_col < MAX_LEN) begin
          res.rw = m_raw[w_col];
          res.rf = m_ref[w_col];
        end
        if (op != OP_DEL) w_row++;
        if (op != OP_INS) w_col++;
        emit_idx++;
        res.step = op;
        res.stuck = dead_end;
        res.last = (emit_idx == n_path);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic add_cmd(logic [2:0] func, logic [7:0] rb, logic seg, logic [7:0] rf,
                         logic [7:0] rw, bit fixed = 0, logic [1:0] kind = KIND_NONE,
                         int cost = 0, int plen = 0);
    cmd_t cmd;
    cmd.func = func;
    cmd.rb = rb;
    cmd.seg = seg;
    cmd.rf = rf;
    cmd.rw = rw;
    cmd.fixed = fixed;
    cmd.res = '0;
    cmd.res.kind = kind;
    cmd.res.cost = 10'(cost);
    cmd.res.plen = 9'(plen);
    cmd_q.insert(cmd_q.size(), cmd);
  endtask

  function automatic logic [7:0] pick_base();
    logic [7:0] bases[8] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h61, 8'h67, 8'h2D, 8'h4E};
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return bases[3'($urandom_range(0, 7))];
  endfunction

  // A command with func, read base and reference base given; segment flag and raw base random.
  task automatic add_rand(logic [2:0] func, logic [7:0] rb, logic [7:0] rf);
    add_cmd(func, rb, 1'($urandom_range(0, 1)), rf, pick_base());
  endtask

  // Sends the queued commands in bursts and records what each one should yield.
  task automatic send_cmds();
    cmd_t cmd;
    align_res_t res;
    while (cmd_q.size() != 0) begin
      cmd = cmd_q.pop_front();
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      in_ch.valid <= 1'b1;
      in_ch.func <= cmd.func;
      in_ch.read_base <= cmd.rb;
      in_ch.segment_end <= cmd.seg;
      in_ch.ref_base <= cmd.rf;
      in_ch.raw_base <= cmd.rw;
      do @(posedge clk); while (!in_ch.ready);
      if (predict_result(cmd, res)) begin
        expected_q.insert(expected_q.size(), cmd.fixed ? cmd.res : res);
      end
      burst_left--;
      sent++;
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected result has come and the block has settled.
  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cost(int value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= MC_W'(value);
    @(posedge clk);
    mc_cfg = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random data set: an optional clear, loads in mixed order with stray other codes, align, then the readout.
  task automatic add_random_set();
    int nr, nf, cols;
    if ($urandom_range(0, 4) != 0) add_rand(FN_CLEAR, 8'($urandom), 8'($urandom));
    nr = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
    nf = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
    while (nr + nf > 0) begin
      if (nf == 0 || (nr > 0 && $urandom_range(0, 1))) begin
        add_rand(FN_LOAD_READ, pick_base(), 8'($urandom));
        nr--;
      end else begin
        add_rand(FN_LOAD_REF, 8'($urandom), pick_base());
        nf--;
      end
      if ($urandom_range(0, 19) == 0) begin
        add_rand(3'($urandom_range(4, 7)), 8'($urandom), 8'($urandom));
      end
    end
    add_rand(FN_ALIGN, 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 5) == 0) add_rand(FN_LOAD_READ, pick_base(), pick_base());
    cols = $urandom_range(0, 30);
    repeat (cols) add_rand(FN_READ_COL, 8'($urandom), 8'($urandom));
  endtask

  // Result side: stall pattern of its own, with one long hold-off on request.
  initial begin
    int mode, span;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 60);
      repeat (span) begin
        out_ch.ready <= (mode == 0) ? 1'b1 :
                        (mode == 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 2) == 0);
        @(posedge clk);
      end
    end
  end

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $realtime, name, want, got);
      errors++;
    end
  endtask

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    align_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: kind %0h", $realtime, out_ch.kind);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", out_ch.kind, want.kind);
        check_field("read_out", out_ch.read_out, want.rd);
        check_field("raw_out", out_ch.raw_out, want.rw);
        check_field("ref_out", out_ch.ref_out, want.rf);
        check_field("step_kind", out_ch.step_kind, want.step);
        check_field("total_cost", out_ch.total_cost, want.cost);
        check_field("path_length", out_ch.path_length, want.plen);
        check_field("no_path", out_ch.no_path, want.stuck);
        check_field("last_column", out_ch.last_column, want.last);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Main sequence.
  initial begin
    int phase;
    in_ch.valid = 1'b0;
    in_ch.func = FN_CLEAR;
    in_ch.read_base = '0;
    in_ch.segment_end = 1'b0;
    in_ch.ref_base = '0;
    in_ch.raw_base = '0;
    n_read = 0;
    n_ref = 0;
    n_path = 0;
    emit_idx = 0;
    w_row = 0;
    w_col = 0;
    dead_end = 0;
    mc_cfg = 2;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: after reset, empty inputs, ignored codes, byte extremes.
    add_cmd(FN_READ_COL, 8'hFF, 1, 8'hFF, 8'hFF, 1, KIND_NONE);
    add_cmd(FN_ALIGN, 8'h00, 0, 8'h00, 8'h00, 1, KIND_SUMMARY, 0, 0);
    add_cmd(FN_READ_COL, 8'h00, 0, 8'h00, 8'h00, 1, KIND_NONE);
    add_cmd(3'd5, 8'hFF, 1, 8'hFF, 8'hFF);
    add_cmd(3'd6, 8'hAA, 0, 8'h55, 8'hAA);
    add_cmd(3'd7, 8'h55, 1, 8'hAA, 8'h55);
    add_cmd(FN_LOAD_READ, 8'h41, 0, 8'hFF, 8'hFF);
    add_cmd(FN_LOAD_READ, 8'h63, 1, 8'h00, 8'h00);
    add_cmd(FN_LOAD_READ, 8'hFF, 1, 8'h00, 8'h00);
    add_cmd(FN_LOAD_READ, 8'h00, 0, 8'h00, 8'h00);
    add_cmd(FN_LOAD_REF, 8'h00, 0, 8'h61, 8'h78);
    add_cmd(FN_LOAD_REF, 8'hFF, 1, 8'h2D, 8'hFF);
    add_cmd(FN_LOAD_REF, 8'h00, 0, 8'h00, 8'h00);
    add_cmd(FN_LOAD_REF, 8'h00, 0, 8'h5A, 8'h7A);
    add_cmd(FN_ALIGN, 8'h00, 0, 8'h00, 8'h00);
    repeat (8) add_cmd(FN_READ_COL, 8'h00, 0, 8'h00, 8'h00);
    add_cmd(FN_CLEAR, 8'hFF, 1, 8'hFF, 8'hFF);
    add_cmd(FN_READ_COL, 8'h00, 0, 8'h00, 8'h00, 1, KIND_NONE);
    send_cmds();

    // Read bases only: the path is all insertions, at the highest cost.
    write_cost(15);
    repeat (5) add_rand(FN_LOAD_READ, pick_base(), 8'($urandom));
    add_rand(FN_ALIGN, 8'($urandom), 8'($urandom));
    repeat (6) add_rand(FN_READ_COL, 8'($urandom), 8'($urandom));
    send_cmds();

    // Stores overfilled: the surplus loads are dropped; one full-size align.
    add_rand(FN_CLEAR, 8'($urandom), 8'($urandom));
    repeat (MAX_LEN + 2) add_rand(FN_LOAD_READ, pick_base(), 8'($urandom));
    repeat (MAX_LEN + 2) add_rand(FN_LOAD_REF, 8'($urandom), pick_base());
    add_rand(FN_ALIGN, 8'($urandom), 8'($urandom));
    repeat (6) add_rand(FN_READ_COL, 8'($urandom), 8'($urandom));
    add_rand(FN_CLEAR, 8'($urandom), 8'($urandom));
    send_cmds();
    write_cost(0);

    // Random data sets, with the cost changed now and then between them.
    phase = 0;
    while (sent < 550) begin
      if (phase > 0 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: write_cost(0);
          1: write_cost(15);
          default: write_cost($urandom_range(0, 15));
        endcase
      end
      add_random_set();
      if (phase == 4) begin
        repeat (40) add_rand(FN_READ_COL, 8'($urandom), 8'($urandom));
        hold_req = 1;
      end
      send_cmds();
      phase++;
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/sga_pkg.sv
design/sga_in_if.sv
design/sga_out_if.sv
design/sga_ram.sv
design/sga_ctrl.sv
design/segmented_semiglobal_alignment_top.sv
bench/tb_top.sv
